[rtl/assert_macros.svh]
// assertion macros included by the interpolator top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/pli_pkg.sv]
// shared constants and types of the interpolator
package pli_pkg;
  localparam int TableDepth = 64;
  localparam int AddrW = $clog2(TableDepth);
  localparam int CntW = AddrW + 1;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_QUERY = 1'b1;
  localparam logic CFG_POINT_COUNT = 1'b0;
  localparam logic CFG_EXTRAP = 1'b1;
  typedef logic signed [31:0] q16_t;
endpackage

[rtl/pli_ram.sv]
// generic single-port ram with registered read
module pli_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

[rtl/piecewise_linear_interpolator.sv]
// piecewise linear interpolator top level
// usage
//   the input channel (in_valid / in_stall) carries one transaction per load or query.
//   opcode load writes point_x / point_y at entry_index and gives no result.
//   opcode query returns one result on the output channel (out_valid / out_stall):
//   y_value, saturated signed q16.16, and degenerate_flag for a zero-width interval.
//   configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0 is
//   point_count (clamped to 2..64), index 1 is extrapolate_enable. write only while idle.
// sequence
//   a load writes both rams as it is accepted, then passes the load state. a query
//   first checks x[n-2], else walks the table one entry at a time through the shared
//   ram address, then runs a bit-serial divider for the slope and a bit-serial
//   multiplier for the product. a zero-width interval leaves the divider right after
//   its operands load and skips the multiplier.
// reset
//   rst sets state to idle, point_count to 2 and extrapolate_enable to 0; other registers
//   and the table contents stay undefined until written. there is no clearing pass.
// stall
//   a finished result sits in the output register until taken; a new transaction is
//   accepted only once the block is back in its idle state.
`include "assert_macros.svh"
module piecewise_linear_interpolator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      opcode,
  input  logic [5:0]                entry_index,
  input  logic signed [31:0]        point_x,
  input  logic signed [31:0]        point_y,
  input  logic signed [31:0]        query_x,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        y_value,
  output logic                      degenerate_flag,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [6:0]                cfg_data
);
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD0   = 4'd1;  // read x[n-2]
  localparam logic [3:0] S_CHK0  = 4'd2;
  localparam logic [3:0] S_RDS   = 4'd3;  // search read x[i+1]
  localparam logic [3:0] S_CHKS  = 4'd4;
  localparam logic [3:0] S_RDXL  = 4'd5;
  localparam logic [3:0] S_RDXR  = 4'd6;
  localparam logic [3:0] S_RDXN  = 4'd7;
  localparam logic [3:0] S_PREP  = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_MUL   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_LOAD  = 4'd13;

  logic [3:0] state;
  logic [pli_pkg::CntW-1:0] point_count;
  logic extrap;
  logic [pli_pkg::AddrW-1:0] nm2, nm1;
  logic [pli_pkg::AddrW-1:0] idx, addr;
  logic [31:0] xr_data, yr_data;
  logic we;
  pli_pkg::q16_t qx, xl, yl, xr, yr, xn;
  logic [6:0] cnt;
  // divider: |dy|<<16 (49 bits) / |dx| (33 bits), restoring, one bit per cycle
  logic [48:0] quo;
  logic [33:0] rem;
  logic [32:0] dvs;
  logic neg_q;
  // multiplier: slope (32 bits) * dxq (33 bits) magnitudes, shift-add
  logic [64:0] prod;
  logic [32:0] mcand;
  logic [31:0] mplier;
  logic neg_p;
  logic degen;
  logic [6:0] pc_clamped;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign nm2 = pli_pkg::AddrW'(point_count - 2);
  assign nm1 = pli_pkg::AddrW'(point_count - 1);
  assign pc_clamped = (cfg_data < 7'd2) ? 7'd2 :
                      (cfg_data > 7'(pli_pkg::TableDepth)) ? 7'(pli_pkg::TableDepth) : cfg_data;

  pli_ram #(.Width(32), .Depth(pli_pkg::TableDepth)) u_xram (
    .clk(clk), .we(we), .addr(addr), .wdata(point_x), .rdata(xr_data));
  pli_ram #(.Width(32), .Depth(pli_pkg::TableDepth)) u_yram (
    .clk(clk), .we(we), .addr(addr), .wdata(point_y), .rdata(yr_data));

  assign we = (state == S_IDLE) && in_valid && (opcode == pli_pkg::OP_LOAD);

  always_comb begin
    unique case (state)
      S_IDLE:  addr = entry_index;
      S_RD0:   addr = nm2;
      S_RDS:   addr = idx + 1'b1;
      S_RDXL:  addr = idx;
      S_RDXR:  addr = idx + 1'b1;
      S_RDXN:  addr = nm1;
      default: addr = idx;
    endcase
  end

  logic signed [32:0] dxw, dyw;
  logic signed [32:0] dxq;
  logic [33:0] trial;
  always_comb begin
    dxw = 33'(xr) - 33'(xl);
    dyw = 33'(yr) - 33'(yl);
    dxq = 33'(qx) - 33'(xl);
    trial = {rem[32:0], quo[48]} - {1'b0, dvs};
  end

  // slope saturation and final sum
  logic signed [31:0] slope_s;
  logic signed [65:0] term_s;
  logic signed [49:0] ysum;
  always_comb begin
    if (quo[48:31] != '0)
      slope_s = neg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else if (neg_q)
      slope_s = -$signed({1'b0, quo[30:0]});
    else
      slope_s = $signed({1'b0, quo[30:0]});
    // truncate toward zero by working on magnitude
    term_s = neg_p ? -$signed({1'b0, 48'(prod >> 16)}) : $signed({1'b0, 48'(prod >> 16)});
    ysum = 50'(yl) + 50'(term_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      point_count <= pli_pkg::CntW'(2);
      extrap <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pli_pkg::CFG_POINT_COUNT) point_count <= pli_pkg::CntW'(pc_clamped);
        else extrap <= cfg_data[0];
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            qx <= query_x;
            idx <= '0;
            state <= (opcode == pli_pkg::OP_QUERY) ? S_RD0 : S_LOAD;
          end
        end
        S_LOAD: state <= S_IDLE;
        S_RD0:  state <= S_CHK0;
        S_CHK0: begin
          if (qx >= $signed(xr_data)) begin
            idx <= nm2;
            state <= S_RDXL;
          end else begin
            state <= S_RDS;
          end
        end
        S_RDS: state <= S_CHKS;
        S_CHKS: begin
          if ((7'(idx) + 7'd1 < 7'(point_count) - 7'd2) && (qx > $signed(xr_data))) begin
            idx <= idx + 1'b1;
            state <= S_RDS;
          end else begin
            state <= S_RDXL;
          end
        end
        S_RDXL: state <= S_RDXR;
        S_RDXR: begin
          xl <= xr_data;
          yl <= yr_data;
          state <= S_RDXN;
        end
        S_RDXN: begin
          xr <= xr_data;
          yr <= yr_data;
          state <= S_PREP;
        end
        S_PREP: begin
          xn <= xr_data;
          // left of the interval wins when both sides hold on an unsorted table
          if (!extrap) begin
            if (qx < xl) yr <= yl;
            else if (qx > xr) yl <= yr;
          end
          state <= S_DIV;
          cnt <= 7'd0;
          rem <= '0;
        end
        S_DIV: begin
          if (cnt == 7'd0) begin
            degen <= (dxw == 0);
            dvs <= dxw[32] ? 33'(-dxw) : 33'(dxw);
            quo <= {(dyw[32] ? 33'(-dyw) : 33'(dyw)), 16'd0};
            neg_q <= dyw[32] ^ dxw[32];
            cnt <= 7'd1;
          end else if (dvs == '0) begin
            state <= S_FIN;
          end else begin
            if (!trial[33]) rem <= trial;
            else rem <= {rem[32:0], quo[48]};
            quo <= {quo[47:0], ~trial[33]};
            if (cnt == 7'd49) begin
              cnt <= 7'd0;
              state <= S_MUL;
            end else begin
              cnt <= cnt + 7'd1;
            end
          end
        end
        S_MUL: begin
          if (cnt == 7'd0) begin
            mcand <= dxq[32] ? 33'(-dxq) : 33'(dxq);
            mplier <= slope_s[31] ? 32'(-slope_s) : 32'(slope_s);
            neg_p <= slope_s[31] ^ dxq[32];
            prod <= '0;
            cnt <= 7'd1;
          end else begin
            if (mplier[0]) prod <= prod + (65'(mcand) << (cnt - 7'd1));
            mplier <= mplier >> 1;
            if (cnt == 7'd32) state <= S_FIN;
            cnt <= cnt + 7'd1;
          end
        end
        S_FIN: begin
          degenerate_flag <= degen;
          if (degen || qx == xn) y_value <= '0;
          else if (ysum > 50'sh7fff_ffff) y_value <= 32'sh7fff_ffff;
          else if (ysum < -50'sh8000_0000) y_value <= 32'sh8000_0000;
          else y_value <= 32'(ysum);
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_busy_stalls, clk, rst, state != S_IDLE, in_stall)
  `ASSERT_NEXT(a_out_holds, clk, rst, out_valid && out_stall, out_valid && $stable(y_value))
  `ASSERT_IMPL(a_count_range, clk, rst, 1'b1,
               point_count >= pli_pkg::CntW'(2) &&
               point_count <= pli_pkg::CntW'(pli_pkg::TableDepth))
endmodule
